// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define TUP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define TUP_ASSERT_NEVER(name, clk, rst_n, cond) \
  `TUP_ASSERT(name, clk, rst_n, !(cond))
`else
`define TUP_ASSERT(name, clk, rst_n, prop)
`define TUP_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

// ===== hw/rtl/tup_pkg.sv =====
// types, constants and character classification for the text to unsigned parser
package tup_pkg;

  localparam int unsigned WordBits   = 32;
  localparam int unsigned OffsetBits = 12;
  localparam int unsigned BaseBits   = 6;
  localparam int unsigned CharBits   = 8;
  localparam int unsigned DigitBits  = 6;

  localparam logic [CharBits-1:0] ChZero  = 8'h30;
  localparam logic [CharBits-1:0] ChNine  = 8'h39;
  localparam logic [CharBits-1:0] ChUpA   = 8'h41;
  localparam logic [CharBits-1:0] ChUpZ   = 8'h5a;
  localparam logic [CharBits-1:0] ChLoA   = 8'h61;
  localparam logic [CharBits-1:0] ChLoZ   = 8'h7a;
  localparam logic [CharBits-1:0] ChUpX   = 8'h58;
  localparam logic [CharBits-1:0] ChLoX   = 8'h78;
  localparam logic [CharBits-1:0] ChMinus = 8'h2d;
  localparam logic [CharBits-1:0] ChPlus  = 8'h2b;
  localparam logic [CharBits-1:0] ChSpace = 8'h20;
  localparam logic [CharBits-1:0] ChTab   = 8'h09;
  localparam logic [CharBits-1:0] ChCr    = 8'h0d;
  localparam logic [CharBits-1:0] UpperBias = ChUpA - 8'd10;
  localparam logic [CharBits-1:0] LowerBias = ChLoA - 8'd10;

  localparam logic [BaseBits-1:0] BaseAuto = 6'd0;
  localparam logic [BaseBits-1:0] BaseOct  = 6'd8;
  localparam logic [BaseBits-1:0] BaseDec  = 6'd10;
  localparam logic [BaseBits-1:0] BaseHex  = 6'd16;

  typedef struct packed {
    logic                  start;
    logic                  ws;
    logic                  minus;
    logic                  plus;
    logic                  xchar;
    logic                  alnum;
    logic [DigitBits-1:0]  dval;
    logic [OffsetBits-1:0] off;
  } tup_item_t;

  function automatic tup_item_t tup_classify(input logic [CharBits-1:0] c);
    tup_item_t    it;
    logic [CharBits-1:0] v;
    it       = '0;
    v        = '0;
    it.ws    = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
    it.minus = (c == ChMinus);
    it.plus  = (c == ChPlus);
    it.xchar = (c == ChLoX) || (c == ChUpX);
    if ((c >= ChZero) && (c <= ChNine)) begin
      it.alnum = 1'b1;
      v        = c - ChZero;
    end else if ((c >= ChUpA) && (c <= ChUpZ)) begin
      it.alnum = 1'b1;
      v        = c - UpperBias;
    end else if ((c >= ChLoA) && (c <= ChLoZ)) begin
      it.alnum = 1'b1;
      v        = c - LowerBias;
    end
    it.dval = v[DigitBits-1:0];
    return it;
  endfunction

endpackage

// ===== hw/rtl/tup_if.sv =====
// request channels of the parser: characters in, results out
interface tup_char_if;
  import tup_pkg::*;
  logic                valid;
  logic                ready;
  logic [CharBits-1:0] text_char;
  logic                string_start;
  modport source(output valid, text_char, string_start, input ready);
  modport sink(input valid, text_char, string_start, output ready);
endinterface

interface tup_result_if;
  import tup_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [WordBits-1:0]   parsed_value;
  logic                  range_error;
  logic [OffsetBits-1:0] end_offset;
  modport source(output valid, parsed_value, range_error, end_offset, input ready);
  modport sink(input valid, parsed_value, range_error, end_offset, output ready);
endinterface

// ===== hw/rtl/tup_front.sv =====
// front end: accepts characters, tracks position and classifies them
module tup_front #(
  parameter int unsigned MAX_STRING_LEN = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  tup_char_if.sink           char_i,
  input  logic               q_full_i,
  output logic               push_o,
  output tup_pkg::tup_item_t item_o
);
  import tup_pkg::*;

  localparam int unsigned PosBits = $clog2(MAX_STRING_LEN);
  localparam logic [PosBits-1:0] PosMax = PosBits'(MAX_STRING_LEN - 1);

  logic [PosBits-1:0]            pos_q, pos_d, pos_cur;
  logic [PosBits+OffsetBits-1:0] pos_ext;

  assign char_i.ready = !q_full_i;
  assign push_o       = char_i.valid && !q_full_i;
  assign pos_cur      = char_i.string_start ? '0 : pos_q;
  assign pos_ext      = {{OffsetBits{1'b0}}, pos_cur};
  assign pos_d        = (pos_cur == PosMax) ? pos_cur : pos_cur + 1'b1;

  always_comb begin
    item_o       = tup_classify(char_i.text_char);
    item_o.start = char_i.string_start;
    item_o.off   = pos_ext[OffsetBits-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (push_o) begin
      pos_q <= pos_d;
    end
  end

endmodule

// ===== hw/rtl/tup_fifo.sv =====
// two-entry queue of classified characters between front and back end
module tup_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  tup_pkg::tup_item_t item_i,
  input  logic               pop_i,
  output logic               valid_o,
  output logic               full_o,
  output tup_pkg::tup_item_t item_o
);
  import tup_pkg::*;

  tup_item_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign valid_o = (count_q != 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

// ===== hw/rtl/tup_back.sv =====
// back end: parse state machine, multiply-add accumulator and result register
module tup_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [tup_pkg::BaseBits-1:0]   number_base_i,
  input  logic                           q_valid_i,
  input  tup_pkg::tup_item_t             item_i,
  output logic                           pop_o,
  tup_result_if.source                   result_o
);
  import tup_pkg::*;

  typedef enum logic [2:0] {
    PH_WS, PH_SIGNED, PH_ZERO, PH_PREFIX, PH_DIGITS, PH_DONE
  } phase_e;

  typedef enum logic [1:0] {DS_NONE, DS_SOME, DS_OVER} dstat_e;

  localparam int unsigned ProdBits = WordBits + BaseBits + 1;

  phase_e                phase_q, phase_d, ph;
  dstat_e                ds_q, ds_d;
  logic                  neg_q, neg_d;
  logic [BaseBits-1:0]   base_q, base_d;
  logic [WordBits-1:0]   acc_q, acc_d;
  logic                  begin_num, dstep, dig_ok;
  logic [ProdBits-1:0]   prod;
  logic                  res_valid, res_err;
  logic [WordBits-1:0]   res_val;
  logic [OffsetBits-1:0] res_off;
  logic                  out_valid_q;
  logic [WordBits-1:0]   out_val_q;
  logic                  out_err_q;
  logic [OffsetBits-1:0] out_off_q;

  assign pop_o = q_valid_i && (!out_valid_q || result_o.ready);

  always_comb begin
    ph        = item_i.start ? PH_WS : phase_q;
    neg_d     = item_i.start ? 1'b0 : neg_q;
    base_d    = item_i.start ? '0 : base_q;
    acc_d     = item_i.start ? '0 : acc_q;
    ds_d      = item_i.start ? DS_NONE : ds_q;
    phase_d   = ph;
    begin_num = 1'b0;
    dstep     = 1'b0;
    res_valid = 1'b0;
    res_err   = 1'b0;
    res_val   = '0;
    res_off   = '0;
    case (ph)
      PH_WS: begin
        if (item_i.ws) begin
          phase_d = PH_WS;
        end else if (item_i.minus) begin
          neg_d   = 1'b1;
          phase_d = PH_SIGNED;
        end else if (item_i.plus) begin
          phase_d = PH_SIGNED;
        end else begin
          begin_num = 1'b1;
        end
      end
      PH_SIGNED: begin
        begin_num = 1'b1;
      end
      PH_ZERO: begin
        if (item_i.xchar) begin
          base_d  = BaseHex;
          phase_d = PH_PREFIX;
        end else begin
          base_d  = (number_base_i == BaseAuto) ? BaseOct : BaseHex;
          acc_d   = '0;
          ds_d    = DS_SOME;
          phase_d = PH_DIGITS;
          dstep   = 1'b1;
        end
      end
      PH_PREFIX: begin
        if (item_i.alnum && (item_i.dval < DigitBits'(BaseHex))) begin
          phase_d = PH_DIGITS;
          dstep   = 1'b1;
        end else begin
          res_valid = 1'b1;
          res_off   = item_i.off - 1'b1;
          phase_d   = PH_DONE;
        end
      end
      PH_DIGITS: begin
        dstep = 1'b1;
      end
      default: begin
        phase_d = ph;
      end
    endcase
    if (begin_num) begin
      if (((number_base_i == BaseAuto) || (number_base_i == BaseHex)) &&
          item_i.alnum && (item_i.dval == '0)) begin
        phase_d = PH_ZERO;
      end else begin
        base_d  = (number_base_i == BaseAuto) ? BaseDec : number_base_i;
        phase_d = PH_DIGITS;
        dstep   = 1'b1;
      end
    end
    dig_ok = item_i.alnum && (item_i.dval < base_d);
    prod   = ProdBits'(acc_d) * ProdBits'(base_d) + ProdBits'(item_i.dval);
    if (dstep) begin
      if (!dig_ok) begin
        res_valid = 1'b1;
        phase_d   = PH_DONE;
        case (ds_d)
          DS_OVER: begin
            res_val = '1;
            res_err = 1'b1;
            res_off = item_i.off;
          end
          DS_SOME: begin
            res_val = neg_d ? ('0 - acc_d) : acc_d;
            res_off = item_i.off;
          end
          default: begin
            res_val = '0;
          end
        endcase
      end else if (ds_d != DS_OVER) begin
        if (prod[ProdBits-1:WordBits] != '0) begin
          ds_d = DS_OVER;
        end else begin
          acc_d = prod[WordBits-1:0];
          ds_d  = DS_SOME;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WS;
      ds_q        <= DS_NONE;
      neg_q       <= 1'b0;
      base_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d;
        ds_q    <= ds_d;
        neg_q   <= neg_d;
        base_q  <= base_d;
        acc_q   <= acc_d;
      end
      if (pop_o && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && res_valid) begin
      out_val_q <= res_val;
      out_err_q <= res_err;
      out_off_q <= res_off;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.parsed_value = out_val_q;
  assign result_o.range_error  = out_err_q;
  assign result_o.end_offset   = out_off_q;

endmodule

// ===== hw/rtl/text_to_unsigned_parser.sv =====
// top level of the streaming text to unsigned integer parser
// Takes one character per cycle and keeps that rate as long as results are taken;
// the back end's combinational multiply-add on the running value sets the figure.
// A terminating character's result passes the queue, then the result register. The
// user must write the base register only while the parser is idle; the block does not
// enforce this. Zero selects octal, decimal or hex from the text. The result holds the
// value, an overflow flag and the terminator's offset (x of a bare 0x; 0 if no digit).
`include "assert_macros.svh"

module text_to_unsigned_parser #(
  parameter int unsigned MAX_STRING_LEN = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tup_pkg::BaseBits-1:0] cfg_wdata_i,
  tup_char_if.sink                     char_i,
  tup_result_if.source                 result_o
);
  import tup_pkg::*;

  logic [BaseBits-1:0] number_base_q;
  logic                push, pop, q_valid, q_full;
  tup_item_t           front_item, q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      number_base_q <= BaseAuto;
    end else if (cfg_we_i) begin
      number_base_q <= cfg_wdata_i;
    end
  end

  tup_front #(
    .MAX_STRING_LEN(MAX_STRING_LEN)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .char_i   (char_i),
    .q_full_i (q_full),
    .push_o   (push),
    .item_o   (front_item)
  );

  tup_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .pop_i   (pop),
    .valid_o (q_valid),
    .full_o  (q_full),
    .item_o  (q_item)
  );

  tup_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .number_base_i (number_base_q),
    .q_valid_i     (q_valid),
    .item_i        (q_item),
    .pop_o         (pop),
    .result_o      (result_o)
  );

  `TUP_ASSERT(a_pop_has_item, clk_i, rst_ni, pop |-> q_valid)
  `TUP_ASSERT(a_stall_holds_back, clk_i, rst_ni, (result_o.valid && !result_o.ready) |-> !pop)
  `TUP_ASSERT(a_queue_keeps_item, clk_i, rst_ni, (q_valid && !pop) |=> q_valid)
  `TUP_ASSERT(a_err_saturates, clk_i, rst_ni, (result_o.valid && result_o.range_error) |-> (&result_o.parsed_value))

endmodule

// ===== sim/tb_text_to_unsigned_parser.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the text to unsigned parser: directed and random strings against a local predictor
module tb_text_to_unsigned_parser;
  import tup_pkg::*;

  localparam logic [CharBits-1:0] ChNul = 8'h00;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned LongHold = 400;
  localparam int unsigned PhaseItems = 100;
  localparam int unsigned LongSpaces = 300;
  localparam int unsigned NoDigit = 99;

  typedef enum logic [2:0] {
    ScanSpace, ScanSign, ScanZero, ScanPrefix, ScanDigits, ScanDone
  } scan_e;
  typedef enum logic [1:0] {DigNone, DigSome, DigOver} dig_e;

  typedef struct packed {
    logic [CharBits-1:0] ch;
    logic                start;
  } char_req_t;

  typedef struct packed {
    logic [WordBits-1:0]   value;
    logic                  err;
    logic [OffsetBits-1:0] offset;
  } number_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [BaseBits-1:0] cfg_wdata_i = '0;
  logic                req_valid = 1'b0;
  logic [CharBits-1:0] req_char = '0;
  logic                req_start = 1'b0;
  logic                res_ready = 1'b0;

  tup_char_if   char_ch ();
  tup_result_if res_ch ();

  assign char_ch.valid        = req_valid;
  assign char_ch.text_char    = req_char;
  assign char_ch.string_start = req_start;
  assign res_ch.ready         = res_ready;

  text_to_unsigned_parser DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .char_i     (char_ch),
    .result_o   (res_ch)
  );

  // predictor state
  scan_e                 scan_phase = ScanSpace;
  logic                  neg_sign = 1'b0;
  logic [BaseBits-1:0]   run_base = '0;
  logic [BaseBits-1:0]   base_reg = '0;
  logic [WordBits-1:0]   acc_value = '0;
  dig_e                  dig_state = DigNone;
  logic [OffsetBits-1:0] char_pos = '0;

  number_t   numbers_due[$];
  char_req_t chars_pending[$];

  int unsigned queued_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned hold_asked = 0;
  int unsigned hold_seen = 0;
  int unsigned send_wait = 0;
  int unsigned send_calm = 0;
  int unsigned recv_wait = 0;
  int unsigned recv_calm = 0;
  logic        char_taken = 1'b0;
  bit          fresh_string = 1'b0;

  function automatic int unsigned char_digit(input logic [CharBits-1:0] c);
    if (c >= ChZero && c <= ChNine) return int'(c - ChZero);
    if (c >= ChUpA && c <= ChUpZ) return int'(c - UpperBias);
    if (c >= ChLoA && c <= ChLoZ) return int'(c - LowerBias);
    return NoDigit;
  endfunction

  function automatic void close_number(input logic [WordBits-1:0] v, input logic e,
                                       input logic [OffsetBits-1:0] o);
    numbers_due.push_back('{value: v, err: e, offset: o});
    scan_phase = ScanDone;
  endfunction

  function automatic void take_digit(input logic [CharBits-1:0] c);
    int unsigned d;
    logic [63:0] sum;
    d = char_digit(c);
    if (d >= run_base) begin
      if (dig_state == DigOver) close_number('1, 1'b1, char_pos);
      else if (dig_state == DigNone) close_number('0, 1'b0, '0);
      else close_number(neg_sign ? (32'd0 - acc_value) : acc_value, 1'b0, char_pos);
    end else if (dig_state != DigOver) begin
      sum = {32'd0, acc_value} * run_base + d;
      if (sum[63:32] != 0) begin
        dig_state = DigOver;
      end else begin
        acc_value = sum[31:0];
        dig_state = DigSome;
      end
    end
  endfunction

  function automatic void open_number(input logic [CharBits-1:0] c);
    if ((base_reg == BaseAuto || base_reg == BaseHex) && c == ChZero) begin
      scan_phase = ScanZero;
    end else begin
      run_base   = (base_reg == BaseAuto) ? BaseDec : base_reg;
      scan_phase = ScanDigits;
      take_digit(c);
    end
  endfunction

  function automatic void scan_char(input logic [CharBits-1:0] c, input logic st);
    if (st) begin
      scan_phase = ScanSpace;
      neg_sign   = 1'b0;
      run_base   = '0;
      acc_value  = '0;
      dig_state  = DigNone;
      char_pos   = '0;
    end
    case (scan_phase)
      ScanSpace: begin
        if (c == ChMinus) begin
          neg_sign   = 1'b1;
          scan_phase = ScanSign;
        end else if (c == ChPlus) begin
          scan_phase = ScanSign;
        end else if (!(c == ChSpace || (c >= ChTab && c <= ChCr))) begin
          open_number(c);
        end
      end
      ScanSign: open_number(c);
      ScanZero: begin
        if (c == ChLoX || c == ChUpX) begin
          run_base   = BaseHex;
          scan_phase = ScanPrefix;
        end else begin
          run_base   = (base_reg == BaseAuto) ? BaseOct : BaseHex;
          acc_value  = '0;
          dig_state  = DigSome;
          scan_phase = ScanDigits;
          take_digit(c);
        end
      end
      ScanPrefix: begin
        if (char_digit(c) < 16) begin
          scan_phase = ScanDigits;
          take_digit(c);
        end else begin
          close_number('0, 1'b0, char_pos - 1'b1);
        end
      end
      ScanDigits: take_digit(c);
      default: ;
    endcase
    if (char_pos != '1) char_pos = char_pos + 1'b1;
  endfunction

  function automatic int unsigned next_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CharBits-1:0] digit_char(input int unsigned d);
    if (d < 10) return ChZero + 8'(d);
    if ($urandom_range(0, 1) == 1) return UpperBias + 8'(d);
    return LowerBias + 8'(d);
  endfunction

  function automatic logic [CharBits-1:0] stop_char(input int unsigned eff);
    logic [CharBits-1:0] c;
    if ($urandom_range(0, 2) == 0) return ChNul;
    c = 8'($urandom_range(0, 255));
    while (char_digit(c) < eff) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  task automatic push_char(input logic [CharBits-1:0] c, input logic st);
    chars_pending.push_back('{ch: c, start: st});
    queued_cnt++;
  endtask

  task automatic push_next(input logic [CharBits-1:0] c);
    push_char(c, fresh_string);
    fresh_string = 1'b0;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_next(s[i]);
  endtask

  task automatic add_random_string(input int unsigned b);
    int unsigned r;
    int unsigned n;
    int unsigned eff;
    int unsigned top;
    logic [63:0] v;
    logic [CharBits-1:0] digs[$];
    fresh_string = 1'b1;
    // noise
    if ($urandom_range(0, 9) == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) push_next(8'($urandom_range(0, 255)));
      return;
    end
    n = $urandom_range(0, 2);
    repeat (n) push_next(($urandom_range(0, 6) == 0) ? ChSpace : 8'($urandom_range(9, 13)));
    r = $urandom_range(0, 9);
    if (r < 2) push_next(ChMinus);
    else if (r == 2) push_next(ChPlus);
    eff = b;
    if ((b == BaseAuto || b == BaseHex) && $urandom_range(0, 3) == 0) begin
      push_next(ChZero);
      push_next($urandom_range(0, 1) ? ChLoX : ChUpX);
      eff = BaseHex;
    end else if (b == BaseAuto) begin
      if ($urandom_range(0, 3) == 0) begin
        push_next(ChZero);
        eff = BaseOct;
      end else begin
        eff = BaseDec;
      end
    end
    r = $urandom_range(0, 99);
    if (eff > 1 && eff <= 36 && r < 12) begin
      // one below and at the wrap of the word
      v = (r < 6) ? 64'hFFFF_FFFF : 64'h1_0000_0000;
      while (v != 0) begin
        digs.push_front(digit_char(int'(v % eff)));
        v = v / eff;
      end
      foreach (digs[i]) push_next(digs[i]);
    end else begin
      n = (r < 16) ? 0 : ((r < 80) ? $urandom_range(1, 8) : $urandom_range(9, 40));
      top = (eff > 36) ? 36 : eff;
      repeat (n) push_next(digit_char($urandom_range(0, top - 1)));
    end
    if ($urandom_range(0, 99) < 85) begin
      push_next(stop_char(eff));
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) push_next(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic settle();
    do @(negedge clk_i); while (taken_cnt != queued_cnt || numbers_due.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_base(input logic [BaseBits-1:0] b);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= b;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    base_reg = b;
    @(posedge clk_i);
  endtask

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    #10ms;
    $display("tb_text_to_unsigned_parser NOT OK");
    $finish;
  end

  always @(posedge clk_i) begin : result_check
    number_t due;
    if (rst_ni) begin
      if (res_ch.valid && res_ready) begin
        if (numbers_due.size() == 0) begin
          $error("parsed_value: expected nothing, got %0h", res_ch.parsed_value);
          err_cnt++;
        end else begin
          due = numbers_due.pop_front();
          if (res_ch.parsed_value !== due.value) begin
            $error("parsed_value: expected %0h, got %0h", due.value, res_ch.parsed_value);
            err_cnt++;
          end
          if (res_ch.range_error !== due.err) begin
            $error("range_error: expected %0d, got %0d", due.err, res_ch.range_error);
            err_cnt++;
          end
          if (res_ch.end_offset !== due.offset) begin
            $error("end_offset: expected %0d, got %0d", due.offset, res_ch.end_offset);
            err_cnt++;
          end
        end
      end
      if (req_valid && char_ch.ready) begin
        scan_char(req_char, req_start);
        taken_cnt++;
      end
      char_taken = req_valid && char_ch.ready;
    end
  end

  always @(negedge clk_i) begin : char_driver
    char_req_t nxt;
    if (rst_ni && (!req_valid || char_taken)) begin
      if (send_wait > 0) begin
        send_wait--;
        req_valid <= 1'b0;
      end else if (chars_pending.size() != 0) begin
        nxt = chars_pending.pop_front();
        req_valid <= 1'b1;
        req_char  <= nxt.ch;
        req_start <= nxt.start;
        if (send_calm > 0) send_calm--;
        else if ($urandom_range(0, 29) == 0) send_calm = $urandom_range(20, 60);
        send_wait = next_gap(send_calm != 0);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : result_receiver
    int unsigned g;
    if (rst_ni) begin
      if (hold_seen != hold_asked) begin
        hold_seen = hold_asked;
        recv_wait = LongHold;
      end
      if (recv_wait > 0) begin
        recv_wait--;
        res_ready <= 1'b0;
      end else begin
        if (recv_calm > 0) recv_calm--;
        else if ($urandom_range(0, 29) == 0) recv_calm = $urandom_range(20, 60);
        g = next_gap(recv_calm != 0);
        res_ready <= (g == 0);
        recv_wait = (g == 0) ? 0 : g - 1;
      end
    end
  end

  initial begin : stimulus
    int unsigned bases [11];
    int unsigned goal;
    bases = '{10, 16, 0, 8, 2, 36, 1, 63, 0, 0, 0};
    bases[8] = $urandom_range(3, 35);
    bases[9] = $urandom_range(37, 62);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // characters before any start flag
    push_char(8'h37, 1'b0);
    push_char(ChNul, 1'b0);
    fresh_string = 1'b1;
    push_next(ChTab);
    push_text("-0x1f");
    push_next(ChNul);
    // prefix with no hex digit after it
    fresh_string = 1'b1;
    push_text("0xg");
    fresh_string = 1'b1;
    push_text("+017");
    push_next(8'hff);
    fresh_string = 1'b1;
    push_text("4294967296Z");
    fresh_string = 1'b1;
    push_text("-");
    push_next(8'h80);
    // trailing characters ignored
    fresh_string = 1'b1;
    push_text("12.5");

    for (int k = 0; k < 11; k++) begin
      settle();
      write_base(BaseBits'(bases[k]));
      if (k == 2 || k == 6) hold_asked++;
      if (k == 0) begin
        // long run of leading spaces
        fresh_string = 1'b1;
        repeat (LongSpaces) push_next(ChSpace);
        push_text("9,");
      end
      goal = queued_cnt + PhaseItems;
      while (queued_cnt < goal) add_random_string(bases[k]);
      // a lone NUL as a new string leaves no number open before the next base change
      fresh_string = 1'b1;
      push_next(ChNul);
    end

    settle();
    if (err_cnt == 0) begin
      $display("tb_text_to_unsigned_parser OK");
    end else begin
      $display("tb_text_to_unsigned_parser NOT OK");
    end
    $finish;
  end

endmodule

// ===== text_to_unsigned_parser.f =====
+incdir+hw/rtl
hw/rtl/tup_pkg.sv
hw/rtl/tup_if.sv
hw/rtl/tup_front.sv
hw/rtl/tup_fifo.sv
hw/rtl/tup_back.sv
hw/rtl/text_to_unsigned_parser.sv
sim/tb_text_to_unsigned_parser.sv
